// ===== hdl/mlfp_pkg.sv =====
// ----------------------------------------------------------------------------
// mlfp_pkg: shared types and constants of the menu line field parser
// Holds the phase codes, the parser state record, the result record and the
// field-end decision.
// ----------------------------------------------------------------------------
package mlfp_pkg;

  localparam logic [2:0] PH_TYPE   = 3'd0;
  localparam logic [2:0] PH_NAME   = 3'd1;
  localparam logic [2:0] PH_SEL    = 3'd2;
  localparam logic [2:0] PH_HOST   = 3'd3;
  localparam logic [2:0] PH_PORT   = 3'd4;
  localparam logic [2:0] PH_ACCEPT = 3'd5;
  localparam logic [2:0] PH_REJECT = 3'd6;

  localparam logic [7:0]  CHAR_SPACE     = 8'h20;
  localparam logic [7:0]  CHAR_TAB       = 8'h09;
  localparam logic [7:0]  CHAR_INFO      = 8'h69;
  localparam logic [7:0]  CHAR_ZERO      = 8'h30;
  localparam logic [7:0]  CHAR_NINE      = 8'h39;
  localparam logic [7:0]  CHAR_NUL       = 8'h00;
  localparam logic [15:0] PORT_FALLBACK  = 16'd70;

  typedef struct packed {
    logic [2:0]  phase;
    logic [9:0]  position;
    logic [7:0]  held_type;
    logic [9:0]  name_count;
    logic [9:0]  selector_offset;
    logic [9:0]  selector_count;
    logic [9:0]  host_offset;
    logic [9:0]  host_count;
    logic [15:0] port_accumulator;
    logic        overflow_seen;
  } parser_state_t;

  typedef struct packed {
    logic        entry_valid;
    logic        is_informational;
    logic [7:0]  item_type;
    logic [9:0]  name_length;
    logic [9:0]  selector_start;
    logic [9:0]  selector_length;
    logic [9:0]  host_start;
    logic [9:0]  host_length;
    logic [15:0] port_number;
    logic        too_long;
  } entry_t;

  localparam parser_state_t STATE_RESET = '{
    phase: PH_TYPE, position: '0, held_type: '0, name_count: '0,
    selector_offset: '0, selector_count: '0, host_offset: '0,
    host_count: '0, port_accumulator: '0, overflow_seen: 1'b0
  };

  // Phase reached when a control byte ends the field in progress.
  function automatic logic [2:0] end_field(input logic [2:0] phase,
                                           input logic [7:0] held_type,
                                           input logic [9:0] name_count,
                                           input logic [7:0] ch);
    logic [2:0] result;
    result = phase;
    case (phase)
      PH_NAME: begin
        if (held_type == CHAR_INFO) begin
          result = (name_count != '0) ? PH_ACCEPT : PH_REJECT;
        end else begin
          result = (ch == CHAR_TAB) ? PH_SEL : PH_REJECT;
        end
      end
      PH_SEL:  result = (ch == CHAR_TAB) ? PH_HOST : PH_REJECT;
      PH_HOST: result = (ch == CHAR_TAB) ? PH_PORT : PH_REJECT;
      PH_PORT: result = PH_ACCEPT;
      default: result = phase;
    endcase
    return result;
  endfunction

endpackage

// ===== hdl/mlfp_if.sv =====
// ----------------------------------------------------------------------------
// mlfp_if: handshake channels of the menu line field parser
// One channel carries line bytes in, the other carries parsed entries out.
// ----------------------------------------------------------------------------
interface mlfp_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] line_byte;
  logic       last_byte;

  modport source (output valid, output line_byte, output last_byte, input ready);
  modport sink (input valid, input line_byte, input last_byte, output ready);
endinterface

interface mlfp_entry_if;
  logic        valid;
  logic        ready;
  logic        entry_valid;
  logic        is_informational;
  logic [7:0]  item_type;
  logic [9:0]  name_length;
  logic [9:0]  selector_start;
  logic [9:0]  selector_length;
  logic [9:0]  host_start;
  logic [9:0]  host_length;
  logic [15:0] port_number;
  logic        too_long;

  modport source (
    output valid, output entry_valid, output is_informational, output item_type,
    output name_length, output selector_start, output selector_length,
    output host_start, output host_length, output port_number, output too_long,
    input ready
  );
  modport sink (
    input valid, input entry_valid, input is_informational, input item_type,
    input name_length, input selector_start, input selector_length,
    input host_start, input host_length, input port_number, input too_long,
    output ready
  );
endinterface

// ===== hdl/mlfp_step.sv =====
// ----------------------------------------------------------------------------
// mlfp_step: per-byte update of the menu line parser
// Computes the parser state after one byte and, for the last byte of a line,
// the finished entry.
// ----------------------------------------------------------------------------
module mlfp_step #(
  parameter logic [9:0] PosLimit = 10'd1023
) (
  input  mlfp_pkg::parser_state_t state,
  input  logic [7:0]              line_byte,
  output mlfp_pkg::parser_state_t state_next,
  output mlfp_pkg::entry_t        entry
);

  mlfp_pkg::parser_state_t upd;
  logic [2:0]  final_phase;
  logic [15:0] port_times_ten;
  logic        valid;
  logic        info;
  logic        full;

  assign port_times_ten = {state.port_accumulator[12:0], 3'b000} +
                          {state.port_accumulator[14:0], 1'b0};

  always_comb begin
    upd = state;
    if (state.position == PosLimit) begin
      upd.overflow_seen = 1'b1;
    end else begin
      upd.position = state.position + 10'd1;
    end
    case (state.phase)
      mlfp_pkg::PH_TYPE: begin
        upd.held_type = line_byte;
        upd.phase = (line_byte == mlfp_pkg::CHAR_NUL) ? mlfp_pkg::PH_REJECT
                                                      : mlfp_pkg::PH_NAME;
      end
      mlfp_pkg::PH_NAME, mlfp_pkg::PH_SEL, mlfp_pkg::PH_HOST: begin
        if (line_byte < mlfp_pkg::CHAR_SPACE) begin
          upd.phase = mlfp_pkg::end_field(state.phase, state.held_type,
                                          state.name_count, line_byte);
          if (upd.phase == mlfp_pkg::PH_SEL) begin
            upd.selector_offset = upd.position;
          end
          if (upd.phase == mlfp_pkg::PH_HOST) begin
            upd.host_offset = upd.position;
          end
        end else if (state.phase == mlfp_pkg::PH_NAME) begin
          if (state.name_count < PosLimit) begin
            upd.name_count = state.name_count + 10'd1;
          end
        end else if (state.phase == mlfp_pkg::PH_SEL) begin
          if (state.selector_count < PosLimit) begin
            upd.selector_count = state.selector_count + 10'd1;
          end
        end else begin
          if (state.host_count < PosLimit) begin
            upd.host_count = state.host_count + 10'd1;
          end
        end
      end
      mlfp_pkg::PH_PORT: begin
        if (line_byte < mlfp_pkg::CHAR_SPACE) begin
          upd.phase = mlfp_pkg::PH_ACCEPT;
        end else if (line_byte >= mlfp_pkg::CHAR_ZERO &&
                     line_byte <= mlfp_pkg::CHAR_NINE) begin
          upd.port_accumulator = port_times_ten + {12'd0, line_byte[3:0]};
        end else begin
          upd.port_accumulator = mlfp_pkg::PORT_FALLBACK;
          upd.phase = mlfp_pkg::PH_ACCEPT;
        end
      end
      default: begin
      end
    endcase
  end

  assign state_next = upd;

  always_comb begin
    if (upd.phase >= mlfp_pkg::PH_NAME && upd.phase <= mlfp_pkg::PH_PORT) begin
      final_phase = mlfp_pkg::end_field(upd.phase, upd.held_type, upd.name_count,
                                        mlfp_pkg::CHAR_NUL);
    end else begin
      final_phase = upd.phase;
    end
  end

  assign valid = (final_phase == mlfp_pkg::PH_ACCEPT);
  assign info  = valid && (upd.held_type == mlfp_pkg::CHAR_INFO);
  assign full  = valid && !info;

  always_comb begin
    entry.entry_valid      = valid;
    entry.is_informational = info;
    entry.item_type        = upd.held_type;
    entry.name_length      = valid ? upd.name_count : '0;
    entry.selector_start   = full ? upd.selector_offset : '0;
    entry.selector_length  = full ? upd.selector_count : '0;
    entry.host_start       = full ? upd.host_offset : '0;
    entry.host_length      = full ? upd.host_count : '0;
    entry.port_number      = full ? upd.port_accumulator : '0;
    entry.too_long         = upd.overflow_seen;
  end

endmodule

// ===== hdl/menu_line_field_parser.sv =====
// ----------------------------------------------------------------------------
// menu_line_field_parser: one-byte-per-cycle menu line parser
// Splits a menu line into type, name, selector, host and port.
// ----------------------------------------------------------------------------
// The line channel carries one byte per transaction; last_byte marks the
// final byte of a line, which is treated as if a NUL followed it.
// The entry channel carries one transaction per line, built from the
// transaction that carried last_byte.
// Each byte updates the parser state in the cycle it is accepted, so the
// block takes one byte per cycle while no last byte waits. The entry appears
// on the entry channel the cycle after its last byte is accepted and sits in
// a single output register. While that register holds an entry the receiver
// has not taken, bytes that are not the last of a line are still accepted; a
// last byte waits until the register is free or taken in the same cycle.
// Reset returns the parser to the start of a line and empties the output
// register. A line longer than the position limit, MAX_LINE - 1 capped at
// 1023, keeps its offsets at the limit and is reported as too long.
// ----------------------------------------------------------------------------
module menu_line_field_parser #(
  parameter int MAX_LINE = 1024
) (
  input logic         clk,
  input logic         rst,
  mlfp_byte_if.sink   line,
  mlfp_entry_if.source entry
);

  localparam logic [9:0] PosLimit = 10'(((MAX_LINE - 1) < 1023) ? (MAX_LINE - 1) : 1023);

  mlfp_pkg::parser_state_t state;
  mlfp_pkg::parser_state_t state_next;
  mlfp_pkg::entry_t        result_next;
  mlfp_pkg::entry_t        result;
  logic                    out_valid;
  logic                    take;

  mlfp_step #(.PosLimit(PosLimit)) u_step (
    .state      (state),
    .line_byte  (line.line_byte),
    .state_next (state_next),
    .entry      (result_next)
  );

  assign line.ready = !out_valid || entry.ready || !line.last_byte;
  assign take       = line.valid && line.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mlfp_pkg::STATE_RESET;
    end else if (take) begin
      state <= line.last_byte ? mlfp_pkg::STATE_RESET : state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take && line.last_byte) begin
      out_valid <= 1'b1;
    end else if (entry.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take && line.last_byte) begin
      result <= result_next;
    end
  end

  assign entry.valid            = out_valid;
  assign entry.entry_valid      = result.entry_valid;
  assign entry.is_informational = result.is_informational;
  assign entry.item_type        = result.item_type;
  assign entry.name_length      = result.name_length;
  assign entry.selector_start   = result.selector_start;
  assign entry.selector_length  = result.selector_length;
  assign entry.host_start       = result.host_start;
  assign entry.host_length      = result.host_length;
  assign entry.port_number      = result.port_number;
  assign entry.too_long         = result.too_long;

  a_last_gives_entry: assert property (@(posedge clk) disable iff (rst)
    take && line.last_byte |=> out_valid)
    else $error("entry not presented after last byte");

  a_last_restarts: assert property (@(posedge clk) disable iff (rst)
    take && line.last_byte |=> state.phase == mlfp_pkg::PH_TYPE && state.position == '0)
    else $error("parser not restarted after last byte");

  a_position_limit: assert property (@(posedge clk) disable iff (rst)
    state.position <= PosLimit && state.name_count <= PosLimit)
    else $error("position beyond limit");

  a_reject_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && !result.entry_valid |->
      result.name_length == '0 && result.port_number == '0 && !result.is_informational)
    else $error("rejected entry carries fields");

  a_info_fields: assert property (@(posedge clk) disable iff (rst)
    out_valid && result.is_informational |->
      result.item_type == mlfp_pkg::CHAR_INFO && result.selector_start == '0 &&
      result.name_length != '0)
    else $error("informational entry malformed");

endmodule

// ===== tb/sv/tb_menu_line_field_parser.sv =====
// ----------------------------------------------------------------------------
// tb_menu_line_field_parser: self-checking testbench of the menu line parser
// Sends menu lines one byte per transaction. The first lines come from a
// directed table and cover field ends, rejects, port wrap and fallback. Random
// lines follow, most of them well formed, plus one line past the position
// limit. Both channels stall at random. Every entry is compared field by
// field with its table row's entry or with a parser model kept in this file.
// ----------------------------------------------------------------------------
module tb_menu_line_field_parser;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LINE_MAX = 1024;
  localparam int POS_MAX = (LINE_MAX - 1 < 1023) ? LINE_MAX - 1 : 1023;
  localparam int TOTAL_BYTES = 1850;
  localparam int LONG_FIELD = 1040;
  localparam int DRAIN_CYCLES = 10;
  localparam longint CYCLE_LIMIT = 1000000;
  localparam logic [7:0] NUL_MARK = 8'h5e;

  typedef struct {
    string            text;
    bit               typed;
    mlfp_pkg::entry_t want;
  } line_row_t;

  typedef struct {
    bit               typed;
    mlfp_pkg::entry_t want;
  } line_check_t;

  // In the table text, a caret stands for a NUL byte.
  line_row_t dir_rows [22] = '{
    '{"1Docs\t/docs\tgopher.example\t70", 1'b0, '0},
    '{"^a\tb\tc\t1", 1'b1, '{1'b0, 1'b0, 8'h00, '0, '0, '0, '0, '0, '0, 1'b0}},
    '{"i", 1'b1, '{1'b0, 1'b0, 8'h69, '0, '0, '0, '0, '0, '0, 1'b0}},
    '{"iHello", 1'b1, '{1'b1, 1'b1, 8'h69, 10'd5, '0, '0, '0, '0, '0, 1'b0}},
    '{"iHi\tsel\thost\t70", 1'b0, '0},
    '{"0name", 1'b1, '{1'b0, 1'b0, 8'h30, '0, '0, '0, '0, '0, '0, 1'b0}},
    '{"0n\tsel", 1'b0, '0},
    '{"0n\ts\th", 1'b1, '{1'b0, 1'b0, 8'h30, '0, '0, '0, '0, '0, '0, 1'b0}},
    '{"0n\ts\th\t", 1'b0, '0},
    '{"1\t\t\t65535", 1'b1,
      '{1'b1, 1'b0, 8'h31, 10'd0, 10'd2, 10'd0, 10'd3, 10'd0, 16'd65535, 1'b0}},
    '{"1a\tb\tc\t65536", 1'b0, '0},
    '{"1a\tb\tc\t99999", 1'b0, '0},
    '{"1a\tb\tc\t7x9", 1'b0, '0},
    '{"1a\tb\tc\t12\015\012junk", 1'b0, '0},
    '{"1a\037b\tc\td\t1", 1'b0, '0},
    '{"\377\177\t\200\t\376\t0", 1'b0, '0},
    '{"\tA\tB\tC\t1", 1'b0, '0},
    '{"1", 1'b1, '{1'b0, 1'b0, 8'h31, '0, '0, '0, '0, '0, '0, 1'b0}},
    '{"1a\tb\tc\t 5", 1'b0, '0},
    '{"1a\tb\tc\t5\t9", 1'b0, '0},
    '{"1a\tb^c\td\t1", 1'b0, '0},
    '{"1a\tb\tc\t8^9", 1'b0, '0}
  };

  logic clk;
  logic rst;

  mlfp_byte_if  line_ch ();
  mlfp_entry_if entry_ch ();

  menu_line_field_parser #(
    .MAX_LINE(LINE_MAX)
  ) i_dut (
    .clk  (clk),
    .rst  (rst),
    .line (line_ch),
    .entry(entry_ch)
  );

  logic [2:0]  stage;
  logic [9:0]  pos;
  logic [7:0]  kind;
  logic [9:0]  name_n;
  logic [9:0]  sel_off;
  logic [9:0]  sel_n;
  logic [9:0]  host_off;
  logic [9:0]  host_n;
  logic [15:0] port_acc;
  logic        overlong;

  mlfp_pkg::entry_t pending_entries [$];
  line_check_t      row_checks [$];
  logic [7:0]       line_bytes [$];
  int unsigned      fail_count = 0;
  longint           cycle_count = 0;
  bit               no_gaps = 1'b0;

  function automatic void clear_parser();
    stage = mlfp_pkg::PH_TYPE;
    pos = '0;
    kind = '0;
    name_n = '0;
    sel_off = '0;
    sel_n = '0;
    host_off = '0;
    host_n = '0;
    port_acc = '0;
    overlong = 1'b0;
  endfunction

  function automatic logic [9:0] bump(input logic [9:0] v);
    return (v < POS_MAX) ? v + 10'd1 : v;
  endfunction

  function automatic void close_field(input logic [7:0] c);
    case (stage)
      mlfp_pkg::PH_NAME: begin
        if (kind == mlfp_pkg::CHAR_INFO) begin
          stage = (name_n != '0) ? mlfp_pkg::PH_ACCEPT : mlfp_pkg::PH_REJECT;
        end else if (c == mlfp_pkg::CHAR_TAB) begin
          sel_off = pos;
          stage = mlfp_pkg::PH_SEL;
        end else begin
          stage = mlfp_pkg::PH_REJECT;
        end
      end
      mlfp_pkg::PH_SEL: begin
        if (c == mlfp_pkg::CHAR_TAB) begin
          host_off = pos;
          stage = mlfp_pkg::PH_HOST;
        end else begin
          stage = mlfp_pkg::PH_REJECT;
        end
      end
      mlfp_pkg::PH_HOST: begin
        stage = (c == mlfp_pkg::CHAR_TAB) ? mlfp_pkg::PH_PORT : mlfp_pkg::PH_REJECT;
      end
      mlfp_pkg::PH_PORT: stage = mlfp_pkg::PH_ACCEPT;
      default: ;
    endcase
  endfunction

  function automatic bit parse_byte(input logic [7:0] c, input logic last,
                                    output mlfp_pkg::entry_t ent);
    logic good;
    logic info;
    ent = '0;
    if (pos == POS_MAX) begin
      overlong = 1'b1;
    end else begin
      pos = pos + 10'd1;
    end
    case (stage)
      mlfp_pkg::PH_TYPE: begin
        kind = c;
        stage = (c == mlfp_pkg::CHAR_NUL) ? mlfp_pkg::PH_REJECT : mlfp_pkg::PH_NAME;
      end
      mlfp_pkg::PH_NAME, mlfp_pkg::PH_SEL, mlfp_pkg::PH_HOST: begin
        if (c < mlfp_pkg::CHAR_SPACE) begin
          close_field(c);
        end else if (stage == mlfp_pkg::PH_NAME) begin
          name_n = bump(name_n);
        end else if (stage == mlfp_pkg::PH_SEL) begin
          sel_n = bump(sel_n);
        end else begin
          host_n = bump(host_n);
        end
      end
      mlfp_pkg::PH_PORT: begin
        if (c < mlfp_pkg::CHAR_SPACE) begin
          close_field(c);
        end else if (c >= mlfp_pkg::CHAR_ZERO && c <= mlfp_pkg::CHAR_NINE) begin
          port_acc = port_acc * 16'd10 + {12'd0, c[3:0]};
        end else begin
          port_acc = mlfp_pkg::PORT_FALLBACK;
          stage = mlfp_pkg::PH_ACCEPT;
        end
      end
      default: ;
    endcase
    if (!last) return 1'b0;
    if (stage >= mlfp_pkg::PH_NAME && stage <= mlfp_pkg::PH_PORT) begin
      close_field(mlfp_pkg::CHAR_NUL);
    end
    good = (stage == mlfp_pkg::PH_ACCEPT);
    info = good && (kind == mlfp_pkg::CHAR_INFO);
    ent.entry_valid = good;
    ent.is_informational = info;
    ent.item_type = kind;
    ent.too_long = overlong;
    if (good) ent.name_length = name_n;
    if (good && !info) begin
      ent.selector_start = sel_off;
      ent.selector_length = sel_n;
      ent.host_start = host_off;
      ent.host_length = host_n;
      ent.port_number = port_acc;
    end
    clear_parser();
    return 1'b1;
  endfunction

  function automatic void check_field(input string field, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      $display("%0t: mismatch on %s, expected %0d, actual %0d", $time, field, want, got);
      fail_count++;
    end
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 40);
  endfunction

  function automatic void load_text(input string s);
    logic [7:0] c;
    line_bytes.delete();
    for (int i = 0; i < s.len(); i++) begin
      c = s[i];
      line_bytes.push_back((c == NUL_MARK) ? mlfp_pkg::CHAR_NUL : c);
    end
  endfunction

  function automatic void add_text(input int n);
    repeat (n) begin
      if ($urandom_range(0, 7) == 0) begin
        line_bytes.push_back(8'($urandom_range(128, 255)));
      end else begin
        line_bytes.push_back(8'($urandom_range(32, 126)));
      end
    end
  endfunction

  function automatic void add_sep();
    if ($urandom_range(0, 9) == 0) begin
      line_bytes.push_back(8'($urandom_range(0, 31)));
    end else begin
      line_bytes.push_back(mlfp_pkg::CHAR_TAB);
    end
  endfunction

  function automatic void add_digits(input int n);
    repeat (n) line_bytes.push_back(mlfp_pkg::CHAR_ZERO + 8'($urandom_range(0, 9)));
  endfunction

  function automatic void add_port();
    add_digits($urandom_range(0, 6));
    case ($urandom_range(0, 9))
      0: begin
        line_bytes.push_back(8'($urandom_range(32, 255)));
        add_digits($urandom_range(0, 3));
      end
      1: begin
        line_bytes.push_back(8'($urandom_range(0, 31)));
        repeat ($urandom_range(0, 4)) line_bytes.push_back(8'($urandom_range(0, 255)));
      end
      default: ;
    endcase
  endfunction

  function automatic void gen_line();
    int shape;
    int keep;
    line_bytes.delete();
    shape = $urandom_range(0, 99);
    if (shape < 8) begin
      repeat ($urandom_range(1, 16)) line_bytes.push_back(8'($urandom_range(0, 255)));
      return;
    end
    if (shape < 20) begin
      line_bytes.push_back(mlfp_pkg::CHAR_INFO);
    end else if (shape < 23) begin
      line_bytes.push_back(mlfp_pkg::CHAR_NUL);
    end else begin
      line_bytes.push_back(8'($urandom_range(1, 255)));
    end
    add_text($urandom_range(0, 12));
    add_sep();
    add_text($urandom_range(0, 16));
    add_sep();
    add_text($urandom_range(0, 12));
    add_sep();
    add_port();
    if (shape >= 90) begin
      keep = $urandom_range(0, line_bytes.size() - 1);
      line_bytes = line_bytes[0:keep];
    end
  endfunction

  function automatic void gen_long_line();
    int which;
    which = $urandom_range(0, 3);
    line_bytes.delete();
    line_bytes.push_back(8'($urandom_range(1, 255)));
    add_text((which == 0) ? LONG_FIELD : 8);
    line_bytes.push_back(mlfp_pkg::CHAR_TAB);
    add_text((which == 1) ? LONG_FIELD : 8);
    line_bytes.push_back(mlfp_pkg::CHAR_TAB);
    add_text((which == 2) ? LONG_FIELD : 8);
    line_bytes.push_back(mlfp_pkg::CHAR_TAB);
    if (which == 3) begin
      add_digits(LONG_FIELD);
    end else begin
      add_port();
    end
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic last);
    int gap;
    gap = no_gaps ? 0 : pick_gap();
    repeat (gap) begin
      @(negedge clk);
      line_ch.valid <= 1'b0;
    end
    @(negedge clk);
    line_ch.valid <= 1'b1;
    line_ch.line_byte <= b;
    line_ch.last_byte <= last;
    do @(posedge clk); while (!line_ch.ready);
  endtask

  task automatic send_line(input bit typed, input mlfp_pkg::entry_t want);
    row_checks.push_back('{typed, want});
    no_gaps = ($urandom_range(0, 4) == 0);
    foreach (line_bytes[i]) send_byte(line_bytes[i], i == line_bytes.size() - 1);
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    int run;
    int hold;
    entry_ch.ready = 1'b0;
    forever begin
      run = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 8);
      repeat (run) begin
        @(negedge clk);
        entry_ch.ready <= 1'b1;
      end
      hold = pick_gap();
      repeat (hold) begin
        @(negedge clk);
        entry_ch.ready <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    mlfp_pkg::entry_t want;
    mlfp_pkg::entry_t ent;
    line_check_t      chk;
    if (!rst) begin
      if (entry_ch.valid && entry_ch.ready) begin
        if (pending_entries.size() == 0) begin
          $display("%0t: unexpected entry, expected none, actual item_type %0d",
                   $time, entry_ch.item_type);
          fail_count++;
        end else begin
          want = pending_entries.pop_front();
          check_field("entry_valid", want.entry_valid, entry_ch.entry_valid);
          check_field("is_informational", want.is_informational, entry_ch.is_informational);
          check_field("item_type", want.item_type, entry_ch.item_type);
          check_field("name_length", want.name_length, entry_ch.name_length);
          check_field("selector_start", want.selector_start, entry_ch.selector_start);
          check_field("selector_length", want.selector_length, entry_ch.selector_length);
          check_field("host_start", want.host_start, entry_ch.host_start);
          check_field("host_length", want.host_length, entry_ch.host_length);
          check_field("port_number", want.port_number, entry_ch.port_number);
          check_field("too_long", want.too_long, entry_ch.too_long);
        end
      end
      if (line_ch.valid && line_ch.ready) begin
        if (parse_byte(line_ch.line_byte, line_ch.last_byte, ent)) begin
          chk = row_checks.pop_front();
          pending_entries.push_back(chk.typed ? chk.want : ent);
        end
      end
    end
  end

  initial begin
    int sent;
    int n;
    rst = 1'b1;
    line_ch.valid = 1'b0;
    line_ch.line_byte = '0;
    line_ch.last_byte = 1'b0;
    clear_parser();
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    sent = 0;
    foreach (dir_rows[r]) begin
      load_text(dir_rows[r].text);
      sent += line_bytes.size();
      send_line(dir_rows[r].typed, dir_rows[r].want);
    end

    n = 0;
    while (sent < TOTAL_BYTES) begin
      if (n == 5) begin
        gen_long_line();
      end else begin
        gen_line();
      end
      sent += line_bytes.size();
      send_line(1'b0, '0);
      n++;
    end
    @(negedge clk);
    line_ch.valid <= 1'b0;

    while (pending_entries.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hdl/mlfp_pkg.sv
hdl/mlfp_if.sv
hdl/mlfp_step.sv
hdl/menu_line_field_parser.sv
tb/sv/tb_menu_line_field_parser.sv
